// ===== design/cbb_pkg.sv =====
// shared types and constants for the circular byte buffer
package cbb_pkg;

    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 7;
    localparam int DEPTH_DEF   = 64;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 2;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // request kinds carried in s_tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // control handed from the sequencer to the row of cells
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  fill;
    } chain_ctrl_t;

endpackage

// ===== design/circular_byte_buffer_unit.sv =====
// circular byte buffer top level: sequencer, counters and output register
//
//  channel | dir | handshake            | carries
//  s_      | in  | s_tvalid / s_tready  | write byte or read request
//  m_      | out | m_tvalid / m_tready  | one result per byte, write or empty read
//  cfg_    | in  | cfg_valid/cfg_ready  | capacity in use
//
// a write item gives one result; a read item of n bytes first takes the
// request and then shifts the lesser of n and the fill level out of cell 0,
// one byte per cycle while the output is not stalled, or gives one result with
// no byte when nothing can be given. the output register takes the next item in
// the cycle its result is taken. reset empties the ring and sets the capacity to
// DEPTH. a stall on m_tready holds the read sequence and blocks s_tready.
module circular_byte_buffer_unit #(
    parameter int DEPTH = cbb_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cbb_pkg::S_TDATA_W-1:0] s_tdata,  // data_byte, read_length, pad
    input  logic                          s_tuser,  // req_type
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cbb_pkg::M_TDATA_W-1:0] m_tdata,  // read_byte, transfer_count,
                                                    // fill_level, pad
    output logic [cbb_pkg::M_TUSER_W-1:0] m_tuser,  // byte_valid, accepted
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cbb_pkg::CNT_W-1:0]     cfg_data
);
    import cbb_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic              state_reg, state_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  wrun_reg, wrun_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              mval_reg, mval_next;
    logic [BYTE_W-1:0] mbyte_reg, mbyte_next;
    logic              mbv_reg, mbv_next;
    logic              macc_reg, macc_next;
    logic [CNT_W-1:0]  mcnt_reg, mcnt_next;
    logic              mlast_reg, mlast_next;
    logic [CNT_W-1:0]  mfill_reg, mfill_next;

    logic [CNT_W-1:0]  cap_eff;
    logic              out_free;
    logic              in_acc;
    logic              cfg_acc;
    logic [BYTE_W-1:0] in_byte;
    logic [CNT_W-1:0]  in_len;
    logic [CNT_W-1:0]  rd_n;
    logic [CNT_W-1:0]  pos_inc;
    logic [BYTE_W-1:0] head_byte;
    chain_ctrl_t       ctrl;

    assign in_byte  = s_tdata[BYTE_W-1:0];
    assign in_len   = s_tdata[BYTE_W+CNT_W-1:BYTE_W];
    assign cfg_ready = 1'b1;
    assign cfg_acc  = cfg_valid;
    assign out_free = !mval_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;
    assign pos_inc  = pos_reg + CNT_W'(1);
    assign rd_n     = (in_len < fill_reg) ? in_len : fill_reg;

    // a capacity of zero counts as one, above DEPTH as DEPTH
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (cap_reg > CNT_W'(DEPTH)) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = cap_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        cap_next   = cap_reg;
        fill_next  = fill_reg;
        wrun_next  = wrun_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        mval_next  = mval_reg && !m_tready;
        mbyte_next = mbyte_reg;
        mbv_next   = mbv_reg;
        macc_next  = macc_reg;
        mcnt_next  = mcnt_reg;
        mlast_next = mlast_reg;
        mfill_next = mfill_reg;
        ctrl.push  = 1'b0;
        ctrl.pop   = 1'b0;
        ctrl.data  = in_byte;
        ctrl.fill  = fill_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    mval_next  = 1'b1;
                    mbyte_next = '0;
                    mbv_next   = 1'b0;
                    macc_next  = 1'b0;
                    if (s_tuser == REQ_WRITE) begin
                        if (fill_reg < cap_eff) begin
                            ctrl.push = 1'b1;
                            fill_next = fill_reg + CNT_W'(1);
                            macc_next = 1'b1;
                            wrun_next = (wrun_reg == CNT_MAX) ? wrun_reg
                                                              : wrun_reg + CNT_W'(1);
                        end
                        mcnt_next  = wrun_next;
                        mlast_next = s_tlast;
                        mfill_next = fill_next;
                        if (s_tlast) begin
                            wrun_next = '0;
                        end
                    end else begin
                        mcnt_next  = '0;
                        mlast_next = 1'b1;
                        mfill_next = fill_reg;
                        if (rd_n != '0) begin
                            // first byte goes out from the read state
                            mval_next  = mval_reg && !m_tready;
                            len_next   = rd_n;
                            pos_next   = '0;
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    ctrl.pop   = 1'b1;
                    mval_next  = 1'b1;
                    mbyte_next = head_byte;
                    mbv_next   = 1'b1;
                    macc_next  = 1'b0;
                    mcnt_next  = pos_inc;
                    mlast_next = (pos_inc == len_reg);
                    fill_next  = fill_reg - CNT_W'(1);
                    mfill_next = fill_next;
                    pos_next   = pos_inc;
                    if (pos_inc == len_reg) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a capacity write empties the ring
        if (cfg_acc) begin
            cap_next   = cfg_data;
            fill_next  = '0;
            wrun_next  = '0;
            state_next = ST_IDLE;
            ctrl.push  = 1'b0;
            ctrl.pop   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cap_reg   <= CNT_W'(DEPTH);
            fill_reg  <= '0;
            wrun_reg  <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            fill_reg  <= fill_next;
            wrun_reg  <= wrun_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        mbyte_reg <= mbyte_next;
        mbv_reg   <= mbv_next;
        macc_reg  <= macc_next;
        mcnt_reg  <= mcnt_next;
        mlast_reg <= mlast_next;
        mfill_reg <= mfill_next;
    end

    cbb_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .head_byte (head_byte)
    );

    assign m_tvalid = mval_reg;
    assign m_tdata  = M_TDATA_W'({mfill_reg, mcnt_reg, mbyte_reg});
    assign m_tuser  = {macc_reg, mbv_reg};
    assign m_tlast  = mlast_reg;

    a_fill_in_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= cap_eff)
        else $error("fill above capacity in use");

    a_read_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> !s_tready)
        else $error("input taken during a read");

    a_read_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ && out_free && !cfg_valid)
        |=> fill_reg == $past(fill_reg) - CNT_W'(1))
        else $error("read byte sent without fill dropping");

    a_read_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> fill_reg != '0)
        else $error("read running on an empty ring");

endmodule

// ===== design/cbb_cell.sv =====
// one byte cell of the shifting store
module cbb_cell (
    input  logic                      aclk,
    input  logic                      load,
    input  logic                      shift,
    input  logic [cbb_pkg::BYTE_W-1:0] load_byte,
    input  logic [cbb_pkg::BYTE_W-1:0] nbr_byte,
    output logic [cbb_pkg::BYTE_W-1:0] cell_byte
);
    import cbb_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (shift) begin
            byte_next = nbr_byte;
        end else if (load) begin
            byte_next = load_byte;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;

endmodule

// ===== design/cbb_chain.sv =====
// row of byte cells: oldest byte in cell 0, new bytes land at the fill position
module cbb_chain #(
    parameter int DEPTH = cbb_pkg::DEPTH_DEF
) (
    input  logic                       aclk,
    input  cbb_pkg::chain_ctrl_t       ctrl,
    output logic [cbb_pkg::BYTE_W-1:0] head_byte
);
    import cbb_pkg::*;

    logic [BYTE_W-1:0] cell_q [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [BYTE_W-1:0] nbr;
        if (i == DEPTH - 1) begin : g_end
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = cell_q[i+1];
        end
        cbb_cell u_cell (
            .aclk      (aclk),
            .load      (ctrl.push && (ctrl.fill == CNT_W'(i))),
            .shift     (ctrl.pop),
            .load_byte (ctrl.data),
            .nbr_byte  (nbr),
            .cell_byte (cell_q[i])
        );
    end

    assign head_byte = cell_q[0];

endmodule
